// ===== src/srs1_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S1 record loader package
// Shared character codes, token and result types, and the parser phases.
// ----------------------------------------------------------------------------
package srs1_pkg;

	localparam logic [7:0] CHAR_S    = 8'h53;
	localparam logic [7:0] CHAR_ONE  = 8'h31;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef enum logic [1:0] {
		EV_WRITE  = 2'd0,
		EV_RECORD = 2'd1,
		EV_ABORT  = 2'd2,
		EV_END    = 2'd3
	} event_kind_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_GOT_S = 3'd1,
		PH_COUNT = 3'd2,
		PH_ADDR  = 3'd3,
		PH_DATA  = 3'd4,
		PH_CHECK = 3'd5
	} phase_t;

	// One classified character as it travels from the front to the back.
	typedef struct packed {
		logic       is_s;
		logic       is_one;
		logic       is_nine;
		logic [3:0] hex;
	} token_t;

	typedef struct packed {
		event_kind_t kind;
		logic [15:0] mem_addr;
		logic [7:0]  mem_data;
		logic [15:0] records_loaded;
		logic [15:0] start_address;
		logic [7:0]  computed_check;
		logic [7:0]  expected_check;
	} result_t;

endpackage
`default_nettype wire

// ===== src/srs1_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S1 record loader queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module srs1_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic                  empty,
	output logic [WIDTH-1:0]      dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count exceeds depth");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty)
		else $error("queue empty after a lone push");
	a_last_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push && count_q == CW'(1)) |=> empty)
		else $error("queue not empty after popping its last beat");
`endif

endmodule
`default_nettype wire

// ===== src/srs1_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S1 record loader front
// Classifies each received character and queues it as a token.
// ----------------------------------------------------------------------------
module srs1_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire logic [7:0]      rx_char,
	input  wire logic            tok_pop,
	output logic                 tok_empty,
	output srs1_pkg::token_t     tok
);

	srs1_pkg::token_t tok_in;

	// Anything that is not a hex digit reads as zero.
	always_comb begin
		tok_in.is_s    = (rx_char == srs1_pkg::CHAR_S);
		tok_in.is_one  = (rx_char == srs1_pkg::CHAR_ONE);
		tok_in.is_nine = (rx_char == srs1_pkg::CHAR_NINE);
		if (rx_char inside {[8'h30:8'h39]}) begin
			tok_in.hex = rx_char[3:0];
		end else if (rx_char inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			tok_in.hex = rx_char[3:0] + 4'd9;
		end else begin
			tok_in.hex = 4'd0;
		end
	end

	srs1_fifo #(
		.WIDTH($bits(srs1_pkg::token_t)),
		.DEPTH(2)
	) u_tok_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.din   (tok_in),
		.pop   (tok_pop),
		.empty (tok_empty),
		.dout  (tok)
	);

endmodule
`default_nettype wire

// ===== src/srs1_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S1 record loader back
// Record parser: assembles bytes, tracks the checksum and queues events.
// ----------------------------------------------------------------------------
module srs1_back #(
	parameter int ADDR_WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             tok_empty,
	output logic                  tok_pop,
	input  wire srs1_pkg::token_t tok,
	input  wire logic             pop,
	output logic                  empty,
	output srs1_pkg::result_t     res
);

	localparam int         ADDR_BYTES = (ADDR_WIDTH + 7) / 8;
	localparam logic [7:0] HDR_BYTES  = 8'(ADDR_BYTES + 1);

	srs1_pkg::phase_t  phase_q, phase_n;
	logic [3:0]            nib_q, nib_n;
	logic                  second_q, second_n;
	logic [7:0]            count_byte_q, count_byte_n;
	logic [7:0]            left_q, left_n;
	logic [ADDR_WIDTH-1:0] wp_q, wp_n;
	logic [7:0]            sum_q, sum_n;
	logic [15:0]           accepted_q, accepted_n;
	logic [ADDR_WIDTH-1:0] origin_q, origin_n;
	logic                  stopped_q, stopped_n;

	logic                  res_full;
	logic                  res_push;
	srs1_pkg::result_t     res_in;
	logic [7:0]            byte_val;
	logic [7:0]            data_cnt;
	logic [7:0]            left_dec;
	logic [7:0]            comp;

	assign tok_pop  = !tok_empty && !res_full;
	assign byte_val = {nib_q, tok.hex};
	assign data_cnt = (count_byte_q >= HDR_BYTES) ? count_byte_q - HDR_BYTES : 8'd0;
	assign left_dec = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;
	assign comp     = ~sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= srs1_pkg::PH_IDLE;
			nib_q        <= '0;
			second_q     <= 1'b0;
			count_byte_q <= '0;
			left_q       <= '0;
			wp_q         <= '0;
			sum_q        <= '0;
			accepted_q   <= '0;
			origin_q     <= '0;
			stopped_q    <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			nib_q        <= nib_n;
			second_q     <= second_n;
			count_byte_q <= count_byte_n;
			left_q       <= left_n;
			wp_q         <= wp_n;
			sum_q        <= sum_n;
			accepted_q   <= accepted_n;
			origin_q     <= origin_n;
			stopped_q    <= stopped_n;
		end
	end

	always_comb begin
		phase_n      = phase_q;
		nib_n        = nib_q;
		second_n     = second_q;
		count_byte_n = count_byte_q;
		left_n       = left_q;
		wp_n         = wp_q;
		sum_n        = sum_q;
		accepted_n   = accepted_q;
		origin_n     = origin_q;
		stopped_n    = stopped_q;
		res_push     = 1'b0;
		res_in       = '0;

		if (tok_pop && !stopped_q) begin
			case (phase_q)
				srs1_pkg::PH_IDLE: begin
					if (tok.is_s) begin
						phase_n = srs1_pkg::PH_GOT_S;
					end
				end
				srs1_pkg::PH_GOT_S: begin
					if (tok.is_one) begin
						second_n = 1'b0;
						sum_n    = 8'd0;
						phase_n  = srs1_pkg::PH_COUNT;
					end else begin
						phase_n = srs1_pkg::PH_IDLE;
						if (tok.is_nine) begin
							stopped_n   = 1'b1;
							res_push    = 1'b1;
							res_in.kind = srs1_pkg::EV_END;
						end
					end
				end
				srs1_pkg::PH_COUNT, srs1_pkg::PH_ADDR, srs1_pkg::PH_DATA,
				srs1_pkg::PH_CHECK: begin
					if (!second_q) begin
						nib_n    = tok.hex;
						second_n = 1'b1;
					end else begin
						second_n = 1'b0;
						case (phase_q)
							srs1_pkg::PH_COUNT: begin
								count_byte_n = byte_val;
								sum_n        = sum_q + byte_val;
								left_n       = 8'(ADDR_BYTES);
								wp_n         = '0;
								phase_n      = srs1_pkg::PH_ADDR;
							end
							srs1_pkg::PH_ADDR: begin
								wp_n  = ADDR_WIDTH'({wp_q, byte_val});
								sum_n = sum_q + byte_val;
								if (left_dec == 8'd0) begin
									left_n  = data_cnt;
									phase_n = (data_cnt != 8'd0) ? srs1_pkg::PH_DATA
										: srs1_pkg::PH_CHECK;
								end else begin
									left_n = left_dec;
								end
							end
							srs1_pkg::PH_DATA: begin
								sum_n           = sum_q + byte_val;
								wp_n            = wp_q + 1'b1;
								left_n          = left_dec;
								if (left_dec == 8'd0) begin
									phase_n = srs1_pkg::PH_CHECK;
								end
								res_push        = 1'b1;
								res_in.kind     = srs1_pkg::EV_WRITE;
								res_in.mem_addr = wp_q[15:0];
								res_in.mem_data = byte_val;
							end
							default: begin
								phase_n               = srs1_pkg::PH_IDLE;
								res_push              = 1'b1;
								res_in.computed_check = comp;
								res_in.expected_check = byte_val;
								if (comp == byte_val) begin
									// The pointer has run past the data, so step back.
									if (accepted_q == 16'd0) begin
										origin_n = wp_q - ADDR_WIDTH'(data_cnt);
									end
									if (accepted_q != 16'hffff) begin
										accepted_n = accepted_q + 16'd1;
									end
									res_in.kind = srs1_pkg::EV_RECORD;
								end else begin
									stopped_n   = 1'b1;
									res_in.kind = srs1_pkg::EV_ABORT;
								end
							end
						endcase
					end
				end
				default: begin
					phase_n = tok.is_s ? srs1_pkg::PH_GOT_S : srs1_pkg::PH_IDLE;
				end
			endcase
		end

		// These two always report the values as they stand after this beat.
		res_in.records_loaded = accepted_n;
		res_in.start_address  = origin_n[15:0];
	end

	srs1_fifo #(
		.WIDTH($bits(srs1_pkg::result_t)),
		.DEPTH(2)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.din   (res_in),
		.pop   (pop),
		.empty (empty),
		.dout  (res)
	);

`ifndef SYNTHESIS
	a_stop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("loader left the stopped state without reset");
	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == srs1_pkg::PH_DATA) |-> (left_q != 8'd0))
		else $error("data phase with no bytes left");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (tok_pop && !res_full))
		else $error("result pushed without a consumed token or room");
	a_quiet_stop: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !res_push)
		else $error("result produced after the load stopped");
`endif

endmodule
`default_nettype wire

// ===== src/srecord_s1_loader_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// S1 record loader
// Parses S1 records from a character stream into memory write events.
// ----------------------------------------------------------------------------
// Input side: one received character per beat on rx_char, taken at a clock
// edge where push is high and full is low. Output side: the oldest event sits
// on the result ports while empty is low and is taken with pop.
// Each character may produce at most one event: a memory write for each data
// byte, a record-accepted or checksum-abort event at the checksum byte, and
// an end event for the S9 marker. After an abort or end, further characters
// are consumed silently until reset.
// An event passes from the token queue through the parser into the event
// queue, and shows on the outputs once it is registered there.
// Throughput is one character per cycle while the event queue is not full,
// set by the parser step in the back end.
// A two-entry token queue sits between the classifier and the parser, and a
// two-entry event queue sits at the output. When the receiver stops popping,
// the parser halts once the event queue holds two events, the token queue
// then fills with the next two characters, and full rises.
// Reset (arst_n low) empties both queues, returns the parser to waiting for
// an S and clears the record count and start address.
// ----------------------------------------------------------------------------
module srecord_s1_loader_unit #(
	parameter int ADDR_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  rx_char,
	input  wire logic        pop,
	output logic             empty,
	output logic [1:0]       event_kind,
	output logic [15:0]      mem_addr,
	output logic [7:0]       mem_data,
	output logic [15:0]      records_loaded,
	output logic [15:0]      start_address,
	output logic [7:0]       computed_check,
	output logic [7:0]       expected_check
);

	srs1_pkg::token_t  tok;
	logic              tok_empty;
	logic              tok_pop;
	srs1_pkg::result_t res;

	srs1_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.rx_char  (rx_char),
		.tok_pop  (tok_pop),
		.tok_empty(tok_empty),
		.tok      (tok)
	);

	srs1_back #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_empty(tok_empty),
		.tok_pop  (tok_pop),
		.tok      (tok),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign event_kind     = res.kind;
	assign mem_addr       = res.mem_addr;
	assign mem_data       = res.mem_data;
	assign records_loaded = res.records_loaded;
	assign start_address  = res.start_address;
	assign computed_check = res.computed_check;
	assign expected_check = res.expected_check;

endmodule
`default_nettype wire
